[design/muxed_seven_segment_capture_top_macros.svh]
// Assertion macros for the seven-segment capture block checker.
`ifndef MUXED_SEVEN_SEGMENT_CAPTURE_TOP_MACROS_SVH
`define MUXED_SEVEN_SEGMENT_CAPTURE_TOP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MSSC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mssc assertion failed");

// Check that a condition is followed by another in the next cycle.
`define MSSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mssc assertion failed");

`endif

[design/mssc_pkg.sv]
// Package: types, constants and the segment table of the seven-segment capture block.
package mssc_pkg;

   localparam int MAX_DIGITS = 4;
   localparam int OUT_DIGITS = 4;
   localparam int SELECT_BITS = 4;
   localparam int STORE_DIGITS = (MAX_DIGITS < SELECT_BITS) ? MAX_DIGITS : SELECT_BITS;

   localparam logic [2:0] COUNT_MIN = 3'd3;
   localparam logic [2:0] COUNT_MAX = 3'd4;
   localparam logic [2:0] COUNT_RESET = 3'd4;
   localparam logic [2:0] COUNT_LIMIT = (MAX_DIGITS < 4) ? 3'(MAX_DIGITS) : COUNT_MAX;

   localparam logic REQ_PORT_WRITE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [7:0] HEX_TABLE [16] = '{
      8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78,
      8'h00, 8'h10, 8'h08, 8'h03, 8'h46, 8'h21, 8'h06, 8'h0E
   };

   typedef struct packed {
      logic       req_type;
      logic [7:0] port_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] seg_digit3;
      logic [7:0] seg_digit2;
      logic [7:0] seg_digit1;
      logic [7:0] seg_digit0;
   } rsp_item_type;

   typedef struct packed {
      logic       fire;
      logic [2:0] digit_count;
   } update_ctrl_type;

   // Clamp the programmed count to the digits really in use.
   function automatic logic [2:0] digits_in_use(input logic [2:0] count);
      logic [2:0] n;
      n = count;
      if (n < COUNT_MIN) n = COUNT_MIN;
      if (n > COUNT_MAX) n = COUNT_MAX;
      if (n > COUNT_LIMIT) n = COUNT_LIMIT;
      return n;
   endfunction

endpackage

[design/muxed_seven_segment_capture_top.sv]
// Top level of the multiplexed seven-segment capture block.
// One request per cycle while req_stall is low. An accepted request is held in
// the input register. When the result side can advance, the per-digit update
// between that register and the result register applies it to the digit state
// and its result is captured for rsp_valid. The sustained rate is one request
// per cycle while rsp_stall is low. A stalled result holds any request in the
// input register, which then stalls the request side. Each request (port write
// or tick) returns exactly one result showing all four digits; digits beyond
// the programmed count, clamped to three or four, read zero. csr_ready is always
// high; write the digit count only while no request is in flight.
module muxed_seven_segment_capture_top
   import mssc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_data
);

   logic            advance;
   logic            item_valid;
   req_item_type    item;
   update_ctrl_type ctrl;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      count_ff, count_in;

   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = advance ? item_valid : rsp_valid_ff;
   assign csr_ready    = 1'b1;
   assign count_in     = (csr_valid && csr_ready) ? csr_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign ctrl.fire        = item_valid && advance;
   assign ctrl.digit_count = count_ff;

   mssc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .advance    (advance),
      .req_stall  (req_stall),
      .item_valid (item_valid),
      .item       (item)
   );

   mssc_digits u_digits (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (item),
      .result (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/mssc_in_stage.sv]
// Input register that holds one request until the update stage takes it.
module mssc_in_stage
   import mssc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_item_type req_data,
   input  logic         advance,
   output logic         req_stall,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // Stall only while a request is held and cannot move on.
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/mssc_digits.sv]
// Digit state, per-digit update and result register.
module mssc_digits
   import mssc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  update_ctrl_type ctrl,
   input  req_item_type    item,
   output rsp_item_type    result
);

   logic [7:0]              seg_ff     [STORE_DIGITS];
   logic [7:0]              seg_in     [STORE_DIGITS];
   logic [STORE_DIGITS-1:0] refresh_ff, refresh_in;
   logic [SELECT_BITS-1:0]  mask_ff, mask_in;
   logic [7:0]              shown      [OUT_DIGITS];
   logic [7:0]              pattern;
   logic [SELECT_BITS-1:0]  new_mask;
   logic [2:0]              n_use;
   rsp_item_type            result_ff;

   assign pattern  = ~HEX_TABLE[item.port_byte[3:0]];
   assign new_mask = item.port_byte[7:4];
   assign n_use    = digits_in_use(ctrl.digit_count);
   assign mask_in  = (item.req_type == REQ_PORT_WRITE) ? new_mask : mask_ff;

   for (genvar i = 0; i < STORE_DIGITS; i++) begin : g_digit
      always_comb begin
         seg_in[i]     = seg_ff[i];
         refresh_in[i] = refresh_ff[i];
         if (3'(i) < n_use) begin
            if (item.req_type == REQ_PORT_WRITE) begin
               if (!new_mask[i]) begin
                  seg_in[i]     = pattern;
                  refresh_in[i] = 1'b1;
               end
            end else if (mask_ff[i] && seg_ff[i] != 8'h00 && !refresh_ff[i]) begin
               // blank a lit digit that was deselected and not refreshed
               seg_in[i] = 8'h00;
            end else begin
               refresh_in[i] = 1'b0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            seg_ff[i]     <= 8'h00;
            refresh_ff[i] <= 1'b0;
         end else if (ctrl.fire) begin
            seg_ff[i]     <= seg_in[i];
            refresh_ff[i] <= refresh_in[i];
         end
      end
   end

   for (genvar i = 0; i < OUT_DIGITS; i++) begin : g_out
      if (i < STORE_DIGITS) begin : g_stored
         assign shown[i] = (3'(i) < n_use) ? seg_in[i] : 8'h00;
      end else begin : g_absent
         assign shown[i] = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '1;
      end else if (ctrl.fire) begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fire) begin
         result_ff.seg_digit0 <= shown[0];
         result_ff.seg_digit1 <= shown[1];
         result_ff.seg_digit2 <= shown[2];
         result_ff.seg_digit3 <= shown[3];
      end
   end

   assign result = result_ff;

endmodule

[design/mssc_checker.sv]
// Port-level checker for the seven-segment capture block, with its bind.
`include "muxed_seven_segment_capture_top_macros.svh"

module mssc_checker
   import mssc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   logic lit_dp_ok;

   assign lit_dp_ok = (rsp_data.seg_digit0 == 8'h00 || rsp_data.seg_digit0[7]) &&
                      (rsp_data.seg_digit1 == 8'h00 || rsp_data.seg_digit1[7]) &&
                      (rsp_data.seg_digit2 == 8'h00 || rsp_data.seg_digit2[7]) &&
                      (rsp_data.seg_digit3 == 8'h00 || rsp_data.seg_digit3[7]);

   // a stalled result holds
   `MSSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // input side stalls only behind a blocked result
   `MSSC_ASSERT(a_stall_cause, req_stall |-> (rsp_valid && rsp_stall))
   // a fresh result follows an accepted request through the input and result registers
   `MSSC_ASSERT(a_rsp_origin, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
   // a lit digit always carries the decimal-point bit
   `MSSC_ASSERT(a_lit_dp, rsp_valid |-> lit_dp_ok)

endmodule

bind muxed_seven_segment_capture_top mssc_checker u_mssc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
